### rtl/mlrt_pkg.sv
// Shared types and constants for the modular linear recurrence term block.
// Holds the sequencer state and multiplier mode enums and the fixed field widths.
// No dependencies.
package mlrt_pkg;

  localparam int COEF_WIDTH  = 32;
  localparam int OUT_WIDTH   = 32;
  localparam int MAT_ENTRIES = 9;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RED,
    ST_INIT,
    ST_EXP,
    ST_PX,
    ST_PY,
    ST_MUL,
    ST_PACC,
    ST_PCOPY,
    ST_F0,
    ST_F1,
    ST_DONE
  } mlrt_state_e;

  typedef enum logic [1:0] {
    MODE_RED,
    MODE_PROD,
    MODE_FIN
  } mlrt_mode_e;

endpackage

### rtl/modular_linear_recurrence_term.sv
// W = max(32, MOD_WIDTH) is the number of bits the bit-serial multiplier walks per modular
// product. An item first reduces a, b, c modulo m, then takes one squaring per bit of n-2
// and one extra product per set bit, i.e. up to about 2*L products for L index bits.
// Throughput: one item at a time; the next item is taken once the sequencer is back in idle.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops any pending result.
//
// Structure: a single shift-and-add modular multiplier takes the multiplier bits MSB first
// (double, then conditional add), each step one add and compare against m. A small
// sequencer walks the square-and-multiply exponent loop from the LSB and, inside each 3x3
// product, the i/j/k indices, accumulating each dot product with a modular adder.
module modular_linear_recurrence_term #(
  parameter int MOD_WIDTH   = 32,
  parameter int INDEX_WIDTH = 60
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [mlrt_pkg::COEF_WIDTH-1:0]  coef_prev_i,
  input  logic [mlrt_pkg::COEF_WIDTH-1:0]  coef_prev2_i,
  input  logic [mlrt_pkg::COEF_WIDTH-1:0]  addend_i,
  input  logic [INDEX_WIDTH-1:0]           term_index_i,
  input  logic [MOD_WIDTH-1:0]             modulus_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [mlrt_pkg::OUT_WIDTH-1:0]   term_value_o
);
  import mlrt_pkg::*;

  // Multiplier operand width: wide enough for a raw 32-bit coefficient or any residue.
  localparam int YW = (MOD_WIDTH > COEF_WIDTH) ? MOD_WIDTH : COEF_WIDTH;
  localparam int CW = $clog2(YW);
  localparam int MW = MOD_WIDTH;

  // (x + y) mod m for x, y < m.
  function automatic logic [MW-1:0] add_mod(input logic [MW-1:0] x,
                                            input logic [MW-1:0] y,
                                            input logic [MW-1:0] m);
    logic [MW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[MW-1:0];
  endfunction

  // Row-major flat index of a 3x3 entry.
  function automatic logic [3:0] mat_idx(input logic [1:0] r, input logic [1:0] c);
    return {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
  endfunction

  // Control state
  mlrt_state_e state_q, state_d;
  mlrt_mode_e  mode_q, mode_d;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic [1:0]  red_idx_q, red_idx_d;
  logic        prod_sq_q, prod_sq_d;
  logic        mph_q, mph_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // Item operands and datapath
  logic [COEF_WIDTH-1:0]  a_q, a_d, b_q, b_d, c_q, c_d;
  logic [INDEX_WIDTH-1:0] e_q, e_d;
  logic [MW-1:0]          m_q, m_d;
  logic [MW-1:0]          acc_q  [MAT_ENTRIES];
  logic [MW-1:0]          acc_d  [MAT_ENTRIES];
  logic [MW-1:0]          base_q [MAT_ENTRIES];
  logic [MW-1:0]          base_d [MAT_ENTRIES];
  logic [MW-1:0]          tmp_q  [MAT_ENTRIES];
  logic [MW-1:0]          tmp_d  [MAT_ENTRIES];
  logic [MW-1:0]          sum_q, sum_d;
  logic [MW-1:0]          mx_q, mx_d, mr_q, mr_d;
  logic [YW-1:0]          my_q, my_d;
  logic [MW-1:0]          res_q, res_d;
  logic [OUT_WIDTH-1:0]   term_q, term_d;

  logic [MW-1:0] one;
  logic [MW-1:0] mul_opb;
  logic [MW-1:0] sum_a, sum_b, sum_res;
  logic [YW-1:0] coef_sel;

  assign one = (m_q == MW'(1)) ? '0 : MW'(1);

  // Doubling step adds r to itself; add step adds x when the current multiplier bit is set.
  assign mul_opb = mph_q ? (my_q[YW-1] ? mx_q : '0) : mr_q;
  assign mr_d    = (state_q == ST_MUL) ? add_mod(mr_q, mul_opb, m_q) :
                   ((state_q == ST_RED || state_q == ST_PY || state_q == ST_F0) ? '0 : mr_q);

  // Dot product accumulator; the final stage first folds acc[0][0] + acc[0][1].
  assign sum_a   = (state_q == ST_F0) ? acc_q[0] : sum_q;
  assign sum_b   = (state_q == ST_F0) ? acc_q[1] : mr_q;
  assign sum_res = add_mod(sum_a, sum_b, m_q);

  always_comb begin
    case (red_idx_q)
      2'd0:    coef_sel = YW'(a_q);
      2'd1:    coef_sel = YW'(b_q);
      default: coef_sel = YW'(c_q);
    endcase
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    out_valid_d = out_valid_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    red_idx_d   = red_idx_q;
    prod_sq_d   = prod_sq_q;
    mph_d       = mph_q;
    cnt_d       = cnt_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    e_d         = e_q;
    m_d         = m_q;
    acc_d       = acc_q;
    base_d      = base_q;
    tmp_d       = tmp_q;
    sum_d       = sum_q;
    mx_d        = mx_q;
    my_d        = my_q;
    res_d       = res_q;
    term_d      = term_q;
    in_stall_o  = (state_q != ST_IDLE);

    // Drop the output item once the sink takes it.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          a_d     = coef_prev_i;
          b_d     = coef_prev2_i;
          c_d     = addend_i;
          e_d     = term_index_i;
          m_d     = modulus_i;
          state_d = ST_CHECK;
        end
      end

      ST_CHECK: begin
        // Zero modulus and short indices finish at once.
        if (m_q == '0) begin
          res_d   = '0;
          state_d = ST_DONE;
        end else if (e_q <= INDEX_WIDTH'(2)) begin
          res_d   = one;
          state_d = ST_DONE;
        end else begin
          e_d       = e_q - INDEX_WIDTH'(2);
          red_idx_d = 2'd0;
          state_d   = ST_RED;
        end
      end

      ST_RED: begin
        // Coefficient mod m as one * coef mod m.
        mx_d    = one;
        my_d    = coef_sel;
        mph_d   = 1'b0;
        cnt_d   = '0;
        mode_d  = MODE_RED;
        state_d = ST_MUL;
      end

      ST_INIT: begin
        for (int n = 0; n < MAT_ENTRIES; n++) begin
          acc_d[n]  = '0;
          base_d[n] = '0;
        end
        acc_d[0]  = one;
        acc_d[4]  = one;
        acc_d[8]  = one;
        base_d[0] = MW'(a_q);
        base_d[1] = MW'(b_q);
        base_d[2] = one;
        base_d[3] = one;
        base_d[8] = one;
        sum_d     = '0;
        i_d       = '0;
        j_d       = '0;
        k_d       = '0;
        state_d   = ST_EXP;
      end

      ST_EXP: begin
        if (e_q == '0) begin
          state_d = ST_F0;
        end else begin
          prod_sq_d = ~e_q[0];
          state_d   = ST_PX;
        end
      end

      ST_PX: begin
        mx_d    = prod_sq_q ? base_q[mat_idx(i_q, k_q)] : acc_q[mat_idx(i_q, k_q)];
        state_d = ST_PY;
      end

      ST_PY: begin
        my_d    = YW'(base_q[mat_idx(k_q, j_q)]);
        mph_d   = 1'b0;
        cnt_d   = '0;
        mode_d  = MODE_PROD;
        state_d = ST_MUL;
      end

      ST_MUL: begin
        mph_d = ~mph_q;
        if (mph_q) begin
          my_d  = my_q << 1;
          cnt_d = cnt_q + CW'(1);
          if (cnt_q == CW'(YW - 1)) begin
            case (mode_q)
              MODE_RED: begin
                case (red_idx_q)
                  2'd0:    a_d = COEF_WIDTH'(mr_d);
                  2'd1:    b_d = COEF_WIDTH'(mr_d);
                  default: c_d = COEF_WIDTH'(mr_d);
                endcase
                if (red_idx_q == 2'd2) begin
                  state_d = ST_INIT;
                end else begin
                  red_idx_d = red_idx_q + 2'd1;
                  state_d   = ST_RED;
                end
              end
              MODE_PROD: state_d = ST_PACC;
              default:   state_d = ST_F1;
            endcase
          end
        end
      end

      ST_PACC: begin
        if (k_q == 2'd2) begin
          tmp_d[mat_idx(i_q, j_q)] = sum_res;
          sum_d = '0;
          k_d   = '0;
          if (j_q == 2'd2) begin
            j_d = '0;
            if (i_q == 2'd2) begin
              i_d     = '0;
              state_d = ST_PCOPY;
            end else begin
              i_d     = i_q + 2'd1;
              state_d = ST_PX;
            end
          end else begin
            j_d     = j_q + 2'd1;
            state_d = ST_PX;
          end
        end else begin
          sum_d   = sum_res;
          k_d     = k_q + 2'd1;
          state_d = ST_PX;
        end
      end

      ST_PCOPY: begin
        // After a squaring, advance the exponent; after acc*base, square next.
        if (prod_sq_q) begin
          base_d  = tmp_q;
          e_d     = e_q >> 1;
          state_d = ST_EXP;
        end else begin
          acc_d     = tmp_q;
          prod_sq_d = 1'b1;
          state_d   = ST_PX;
        end
      end

      ST_F0: begin
        sum_d   = sum_res;
        mx_d    = MW'(c_q);
        my_d    = YW'(acc_q[2]);
        mph_d   = 1'b0;
        cnt_d   = '0;
        mode_d  = MODE_FIN;
        state_d = ST_MUL;
      end

      ST_F1: begin
        res_d   = sum_res;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        // Hold until the output register is free or being taken.
        if (!out_valid_q || !out_stall_i) begin
          term_d      = OUT_WIDTH'(res_q);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_RED;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      red_idx_q   <= '0;
      prod_sq_q   <= 1'b0;
      mph_q       <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      red_idx_q   <= red_idx_d;
      prod_sq_q   <= prod_sq_d;
      mph_q       <= mph_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    e_q    <= e_d;
    m_q    <= m_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    tmp_q  <= tmp_d;
    sum_q  <= sum_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    mr_q   <= mr_d;
    res_q  <= res_d;
    term_q <= term_d;
  end

  assign out_valid_o  = out_valid_q;
  assign term_value_o = term_q;

endmodule

### tb/sv/modular_linear_recurrence_term_tb.sv
// Self-checking testbench for modular_linear_recurrence_term: directed and random items,
// each result checked against a matrix-power predictor of g(n) mod m.
// Depends on rtl/mlrt_pkg.sv and rtl/modular_linear_recurrence_term.sv.
`timescale 1ns / 1ps

module modular_linear_recurrence_term_tb;

  localparam int MOD_WIDTH    = 32;
  localparam int INDEX_WIDTH  = 60;
  localparam int CW           = mlrt_pkg::COEF_WIDTH;
  localparam int OW           = mlrt_pkg::OUT_WIDTH;
  localparam int PW           = 2 * MOD_WIDTH;
  localparam int RESET_CYCLES = 11;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 500;
  localparam int RANDOM_ITEMS = 117;

  // Receiver stall modes: never stall, stall on a coin flip, stall in long runs.
  typedef enum int {RX_FREE, RX_COIN, RX_RUNS} rx_mode_e;

  // One 3x3 matrix of residues, entry (i,j) at index i*3+j.
  typedef logic [8:0][MOD_WIDTH-1:0] mat9_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [CW-1:0]          coef_prev_i;
  logic [CW-1:0]          coef_prev2_i;
  logic [CW-1:0]          addend_i;
  logic [INDEX_WIDTH-1:0] term_index_i;
  logic [MOD_WIDTH-1:0]   modulus_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [OW-1:0]          term_value_o;

  logic [OW-1:0] expected_terms[$];
  logic [OW-1:0] want_term;
  int            fail_count = 0;
  int            burst_left = 0;
  bit            hold_req   = 1'b0;

  modular_linear_recurrence_term #(
    .MOD_WIDTH  (MOD_WIDTH),
    .INDEX_WIDTH(INDEX_WIDTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .coef_prev_i (coef_prev_i),
    .coef_prev2_i(coef_prev2_i),
    .addend_i    (addend_i),
    .term_index_i(term_index_i),
    .modulus_i   (modulus_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .term_value_o(term_value_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Product of two residue matrices, every product and sum reduced modulo m.
  function automatic mat9_t mat3_mulmod(input mat9_t p, input mat9_t q,
                                        input logic [MOD_WIDTH-1:0] m);
    mat9_t         r;
    logic [PW-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sum = '0;
        for (int k = 0; k < 3; k++)
          sum = (sum + (PW'(p[i*3+k]) * PW'(q[k*3+j])) % PW'(m)) % PW'(m);
        r[i*3+j] = sum[MOD_WIDTH-1:0];
      end
    end
    return r;
  endfunction

  // Term n of g(1)=g(2)=1, g(k)=a*g(k-1)+b*g(k-2)+c, modulo m (zero when m is zero).
  function automatic logic [OW-1:0] predict_term(input logic [CW-1:0] a,
                                                 input logic [CW-1:0] b,
                                                 input logic [CW-1:0] c,
                                                 input logic [INDEX_WIDTH-1:0] n,
                                                 input logic [MOD_WIDTH-1:0] m);
    mat9_t                  base;
    mat9_t                  acc;
    logic [INDEX_WIDTH-1:0] e;
    logic [MOD_WIDTH-1:0]   one;
    logic [PW-1:0]          t;
    if (m == '0) return '0;
    one = (m == 1) ? '0 : MOD_WIDTH'(1);
    if (n <= 2) return OW'(one);
    base    = '0;
    acc     = '0;
    base[0] = MOD_WIDTH'(PW'(a) % PW'(m));
    base[1] = MOD_WIDTH'(PW'(b) % PW'(m));
    base[2] = one;
    base[3] = one;
    base[8] = one;
    acc[0]  = one;
    acc[4]  = one;
    acc[8]  = one;
    // Walk the exponent n-2 from its LSB: multiply on set bits, square every step.
    e = n - 2;
    while (e != '0) begin
      if (e[0]) acc = mat3_mulmod(acc, base, m);
      base = mat3_mulmod(base, base, m);
      e = e >> 1;
    end
    t = (PW'(acc[0]) + PW'(acc[1])) % PW'(m);
    t = (t + ((PW'(c) % PW'(m)) * PW'(acc[2])) % PW'(m)) % PW'(m);
    return t[OW-1:0];
  endfunction

  // Offer one item in bursts with random gaps; record its expected term on acceptance.
  // Enter and leave at a falling edge, valid left high for a following item.
  task automatic send_term_request(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                   input logic [CW-1:0] c,
                                   input logic [INDEX_WIDTH-1:0] n,
                                   input logic [MOD_WIDTH-1:0] m);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    coef_prev_i  <= a;
    coef_prev2_i <= b;
    addend_i     <= c;
    term_index_i <= n;
    modulus_i    <= m;
    do @(posedge clk_i); while (in_stall_o);
    expected_terms.push_back(predict_term(a, b, c, n, m));
    @(negedge clk_i);
  endtask

  // Coefficient mix: zero, all ones, small values and full random words.
  function automatic logic [CW-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return CW'($urandom_range(0, 15));
      default: return CW'($urandom());
    endcase
  endfunction

  // Modulus mix: rare zero, one, small, near the top, a large prime and random words.
  function automatic logic [MOD_WIDTH-1:0] pick_modulus();
    case ($urandom_range(0, 31))
      0:       return '0;
      1, 2:    return MOD_WIDTH'(1);
      3, 4, 5: return MOD_WIDTH'($urandom_range(2, 64));
      6, 7:    return '1;
      8, 9:    return '1 - MOD_WIDTH'($urandom_range(1, 255));
      10, 11:  return MOD_WIDTH'(1_000_000_007);
      default: return MOD_WIDTH'($urandom());
    endcase
  endfunction

  // Keep most indexes tiny so the run stays short; every 16th item gets a wider one.
  function automatic logic [INDEX_WIDTH-1:0] pick_index(input int seq);
    if (seq % 16 == 15) return INDEX_WIDTH'($urandom_range(7, 4095));
    if ($urandom_range(0, 3) == 0) return INDEX_WIDTH'($urandom_range(0, 2));
    return INDEX_WIDTH'($urandom_range(3, 6));
  endfunction

  // Short index: n of 0, 1 or 2 gives 1 mod m, which is 0 for m of one.
  task automatic test_short_index();
    send_term_request('1, '1, '1, 0, '1);
    send_term_request('0, '0, '0, 1, 1);
    send_term_request(5, 7, 9, 2, 1);
    send_term_request(5, 7, 9, 2, 2);
    send_term_request('1, '0, '1, 1, 12345);
  endtask

  // Zero modulus: the term reads zero whatever the index.
  task automatic test_zero_modulus();
    send_term_request(3, 4, 5, 0, '0);
    send_term_request(3, 4, 5, 7, '0);
    send_term_request('1, '1, '1, 9, '0);
  endtask

  // Operand extremes, plain Fibonacci and coefficients larger than the modulus.
  task automatic test_extreme_operands();
    send_term_request(1, 1, 0, 10, 1000);
    send_term_request('1, '1, '1, 3, '1);
    send_term_request('1, '1, '1, 6, '1 - 1);
    send_term_request('1 - 1, '1 - 2, '1 - 3, 7, '1);
    send_term_request('0, '0, '0, 5, 7);
    send_term_request(2, 3, 1, 20, 1);
    send_term_request(12345, 67890, '1, 17, 2);
    send_term_request(1, 1, 1, 16, 1_000_000_007);
  endtask

  // Full-width index: a large index, and the all-ones index, the largest index in use.
  task automatic test_full_index();
    send_term_request(1, 1, 0, 60'd1_000_000_000_000_000_000, 1_000_000_007);
    send_term_request('1 - 1, '1, 32'h1234_5678, '1, '1);
  endtask

  // Hold the result side off for a long stretch while items keep coming, so the
  // block fills up and stalls its input.
  task automatic test_input_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 5; i++)
      send_term_request(pick_coef(), pick_coef(), pick_coef(),
                        INDEX_WIDTH'($urandom_range(0, 4)), pick_modulus());
  endtask

  task automatic test_random_items();
    for (int i = 0; i < RANDOM_ITEMS; i++)
      send_term_request(pick_coef(), pick_coef(), pick_coef(), pick_index(i),
                        pick_modulus());
  endtask

  // Result side: drive stall on a pattern of its own, switched between modes at random,
  // and count out the long hold-off here when asked.
  initial begin : rx_stall_proc
    int       hold_left;
    int       mode_left;
    int       run_left;
    bit       run_stall;
    rx_mode_e mode;
    hold_left   = 0;
    mode_left   = 0;
    run_left    = 0;
    run_stall   = 1'b0;
    mode        = RX_FREE;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 400);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          RX_FREE: out_stall_i <= 1'b0;
          RX_COIN: out_stall_i <= 1'($urandom_range(0, 1));
          default: begin
            if (run_left == 0) begin
              run_left  = $urandom_range(1, 30);
              run_stall = ~run_stall;
            end
            run_left--;
            out_stall_i <= run_stall;
          end
        endcase
      end
    end
  end

  // Check each accepted result against the oldest expected term.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_terms.size() == 0) begin
        $error("term_value: result with no item pending, expected none, actual %0d",
               term_value_o);
        fail_count++;
      end else begin
        want_term = expected_terms.pop_front();
        if (term_value_o !== want_term) begin
          $error("term_value mismatch: expected %0d, actual %0d", want_term, term_value_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    coef_prev_i  = '0;
    coef_prev2_i = '0;
    addend_i     = '0;
    term_index_i = '0;
    modulus_i    = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_short_index();
    test_zero_modulus();
    test_extreme_operands();
    test_full_index();
    test_input_backpressure();
    test_random_items();

    // Drop valid, let every expected term come back, then watch for strays.
    in_valid_i <= 1'b0;
    while (expected_terms.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Abort a hung run; the slowest legal run is a small fraction of this.
  initial begin
    #80_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
